>>> hw/rtl/cac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cac_pkg;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [63:0] point_tag;
		logic        last_point;
	} point_t;

	typedef struct packed {
		logic [63:0] out_tag;
		logic [5:0]  group_index;
		logic        group_end;
		logic        run_end;
	} result_t;

	localparam int DIST_W = 33;
	localparam logic [DIST_W-1:0] DIST_RESET = 33'd14745600;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_RD,
		S_DIFF,
		S_SQ,
		S_CMP,
		S_MRD,
		S_MUL_A,
		S_MUL_B,
		S_ADD,
		S_DIV,
		S_MWR,
		S_SHR,
		S_SHW,
		S_OG,
		S_OGL,
		S_OP,
		S_OE
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/centroid_agglomerative_clusterer.sv
// centroid agglomerative clusterer
// points enter on the command channel: one transfer per cycle while busy is low
// (start high, busy low). each point is stored as its own group; points beyond
// MAX_POINTS are dropped. a point with last_point set starts the clustering run
// and busy stays high until every result has been issued.
// clustering repeats a pair scan and a merge. the scan walks all pairs of
// surviving groups through one distance unit, one pair at a time (read,
// difference, square, compare). a merge sums x, then y, weighted by size, and
// divides with a one-bit-per-cycle divider (NW = 17 + clog2(MAX_POINTS+1)),
// then shifts later slots down. result issue walks each group's points in turn.
// results appear on result with result_valid high for one cycle each; the
// receiver cannot stall, so nothing waits. the threshold register is written
// through cfg_valid/cfg_ready, ready whenever the block is idle.
// reset (arst_n low) empties the point set and restores the threshold; the
// point and group stores are not cleared, every entry is written before use.
`timescale 1ns / 1ps
`default_nettype none

module centroid_agglomerative_clusterer
	import cac_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire point_t            point,
	output logic                   result_valid,
	output result_t                result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [DIST_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NW = 16 + CW + 1;
	localparam int DCW = $clog2(NW + 1);

	typedef struct packed {
		logic [15:0]   cx;
		logic [15:0]   cy;
		logic [63:0]   tag;
		logic [CW-1:0] size;
		logic [IW-1:0] head;
		logic [IW-1:0] tail;
	} grp_t;

	grp_t        gmem [MAX_POINTS];
	logic [63:0] tmem [MAX_POINTS];
	logic [IW-1:0] lmem [MAX_POINTS];

	state_t state_q, state_d;

	logic [DIST_W-1:0] max_d_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     i_q, j_q, k_q, g_q, p_q;
	logic [IW-1:0]     keep_q, drop_q;
	logic [CW-1:0]     m_q, sz_q;
	grp_t              rd_a_q, rd_b_q;
	logic [63:0]       tag_rd_q;
	logic [IW-1:0]     link_rd_q;
	logic [15:0]       dx_q, dy_q;
	logic [31:0]       dx2_q, dy2_q;
	logic [95:0]       lo_key_q, hi_key_q, best_lo_key_q, best_hi_key_q;
	logic [IW-1:0]     lo_slot_q, hi_slot_q, best_lo_q, best_hi_q;
	logic [DIST_W-1:0] best_d_q;
	logic              found_q;
	logic              ph_q;
	logic [NW-1:0]     num_q, prod_q;
	logic [CW-1:0]     rem_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [15:0]       cxn_q;
	logic              res_valid_q;
	result_t           res_q;

	// control
	logic          accept, load_ok;
	logic          rd_ga_en, rd_gb_en, rd_p_en;
	logic [IW-1:0] addr_a, addr_b;
	logic          gwe;
	logic [IW-1:0] gwa;
	grp_t          gwd;
	logic          lwe;

	// datapath combinational
	logic [95:0]       key_a, key_b;
	logic              a_less;
	logic [DIST_W-1:0] d_sum;
	logic              qual, better, upd;
	logic              j_more, i_more;
	logic [15:0]       ck, cd;
	logic [CW-1:0]     den;
	logic [CW:0]       trial;
	logic              ge;
	logic [NW-1:0]     num_step;
	logic              g_more, m_last;

	assign accept  = start && !busy;
	assign load_ok = cnt_q < CW'(MAX_POINTS);

	assign key_a  = {rd_a_q.cx, rd_a_q.cy, rd_a_q.tag};
	assign key_b  = {rd_b_q.cx, rd_b_q.cy, rd_b_q.tag};
	assign a_less = key_a < key_b;

	assign d_sum  = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign qual   = d_sum <= max_d_q;
	assign better = !found_q || d_sum < best_d_q ||
		(d_sum == best_d_q && (lo_key_q < best_lo_key_q ||
		(lo_key_q == best_lo_key_q && hi_key_q < best_hi_key_q)));
	assign upd    = qual && better;
	assign j_more = (CW'(j_q) + CW'(1)) < cnt_q;
	assign i_more = (CW'(i_q) + CW'(2)) < cnt_q;

	assign ck    = ph_q ? rd_a_q.cy : rd_a_q.cx;
	assign cd    = ph_q ? rd_b_q.cy : rd_b_q.cx;
	assign den   = rd_a_q.size + rd_b_q.size;
	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den};
	assign num_step = {num_q[NW-2:0], ge};

	assign g_more = (CW'(g_q) + CW'(1)) < cnt_q;
	assign m_last = (m_q + CW'(1)) == sz_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept && point.last_point) state_d = S_INIT;
			S_INIT: state_d = (cnt_q > CW'(1)) ? S_RD : S_OG;
			S_RD:   state_d = S_DIFF;
			S_DIFF: state_d = S_SQ;
			S_SQ:   state_d = S_CMP;
			S_CMP: begin
				if (j_more || i_more) state_d = S_RD;
				else state_d = (found_q || upd) ? S_MRD : S_OG;
			end
			S_MRD:   state_d = S_MUL_A;
			S_MUL_A: state_d = S_MUL_B;
			S_MUL_B: state_d = S_ADD;
			S_ADD:   state_d = S_DIV;
			S_DIV: begin
				if (div_cnt_q == DCW'(1)) state_d = ph_q ? S_MWR : S_MUL_A;
			end
			S_MWR: state_d = S_SHR;
			S_SHR: state_d = ((CW'(k_q) + CW'(1)) < cnt_q) ? S_SHW : S_INIT;
			S_SHW: state_d = S_SHR;
			S_OG:  state_d = S_OGL;
			S_OGL: state_d = S_OP;
			S_OP:  state_d = S_OE;
			S_OE: begin
				if (!m_last) state_d = S_OP;
				else state_d = g_more ? S_OG : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy     = state_q != S_IDLE;
		cfg_ready = state_q == S_IDLE;
		rd_ga_en = 1'b0;
		rd_gb_en = 1'b0;
		rd_p_en  = 1'b0;
		addr_a   = i_q;
		addr_b   = j_q;
		gwe      = 1'b0;
		gwa      = cnt_q[IW-1:0];
		gwd      = rd_a_q;
		lwe      = 1'b0;
		case (state_q)
			S_IDLE: begin
				gwe = accept && load_ok;
				gwd = '{cx: point.pos_x, cy: point.pos_y, tag: point.point_tag,
					size: CW'(1), head: cnt_q[IW-1:0], tail: cnt_q[IW-1:0]};
			end
			S_RD: begin
				rd_ga_en = 1'b1;
				rd_gb_en = 1'b1;
			end
			S_MRD: begin
				rd_ga_en = 1'b1;
				rd_gb_en = 1'b1;
				addr_a   = (best_lo_q < best_hi_q) ? best_lo_q : best_hi_q;
				addr_b   = (best_lo_q < best_hi_q) ? best_hi_q : best_lo_q;
			end
			S_MWR: begin
				gwe = 1'b1;
				gwa = keep_q;
				lwe = 1'b1;
				gwd = '{cx: cxn_q, cy: num_q[15:0],
					tag: (rd_b_q.tag < rd_a_q.tag) ? rd_b_q.tag : rd_a_q.tag,
					size: den, head: rd_a_q.head, tail: rd_b_q.tail};
			end
			S_SHR: begin
				rd_ga_en = 1'b1;
				addr_a   = k_q + IW'(1);
			end
			S_SHW: begin
				gwe = 1'b1;
				gwa = k_q;
				gwd = rd_a_q;
			end
			S_OG: begin
				rd_ga_en = 1'b1;
				addr_a   = g_q;
			end
			S_OP: rd_p_en = 1'b1;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (gwe) gmem[gwa] <= gwd;
		if (state_q == S_IDLE && accept && load_ok) tmem[cnt_q[IW-1:0]] <= point.point_tag;
		if (lwe) lmem[rd_a_q.tail] <= rd_b_q.head;
		if (rd_ga_en) rd_a_q <= gmem[addr_a];
		if (rd_gb_en) rd_b_q <= gmem[addr_b];
		if (rd_p_en) begin
			tag_rd_q  <= tmem[p_q];
			link_rd_q <= lmem[p_q];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: begin
				i_q <= '0;
				j_q <= IW'(1);
			end
			S_DIFF: begin
				dx_q      <= (rd_a_q.cx > rd_b_q.cx) ? rd_a_q.cx - rd_b_q.cx
					: rd_b_q.cx - rd_a_q.cx;
				dy_q      <= (rd_a_q.cy > rd_b_q.cy) ? rd_a_q.cy - rd_b_q.cy
					: rd_b_q.cy - rd_a_q.cy;
				lo_key_q  <= a_less ? key_a : key_b;
				hi_key_q  <= a_less ? key_b : key_a;
				lo_slot_q <= a_less ? i_q : j_q;
				hi_slot_q <= a_less ? j_q : i_q;
			end
			S_SQ: begin
				dx2_q <= dx_q * dx_q;
				dy2_q <= dy_q * dy_q;
			end
			S_CMP: begin
				if (upd) begin
					best_d_q      <= d_sum;
					best_lo_key_q <= lo_key_q;
					best_hi_key_q <= hi_key_q;
					best_lo_q     <= lo_slot_q;
					best_hi_q     <= hi_slot_q;
				end
				if (j_more) begin
					j_q <= j_q + IW'(1);
				end else if (i_more) begin
					i_q <= i_q + IW'(1);
					j_q <= i_q + IW'(2);
				end
			end
			S_MRD: begin
				keep_q <= (best_lo_q < best_hi_q) ? best_lo_q : best_hi_q;
				drop_q <= (best_lo_q < best_hi_q) ? best_hi_q : best_lo_q;
			end
			S_MUL_A: num_q  <= NW'(ck * rd_a_q.size);
			S_MUL_B: prod_q <= NW'(cd * rd_b_q.size);
			S_ADD: begin
				num_q     <= num_q + prod_q;
				rem_q     <= '0;
				div_cnt_q <= DCW'(NW);
			end
			S_DIV: begin
				num_q     <= num_step;
				rem_q     <= ge ? CW'(trial - {1'b0, den}) : CW'(trial);
				div_cnt_q <= div_cnt_q - DCW'(1);
				if (div_cnt_q == DCW'(1) && !ph_q) cxn_q <= num_step[15:0];
			end
			S_MWR: k_q <= drop_q;
			S_SHW: k_q <= k_q + IW'(1);
			S_OGL: begin
				p_q  <= rd_a_q.head;
				sz_q <= rd_a_q.size;
				m_q  <= '0;
			end
			S_OE: begin
				p_q <= link_rd_q;
				m_q <= m_q + CW'(1);
				if (m_last) g_q <= g_q + IW'(1);
			end
			default: ;
		endcase
		if (state_q == S_INIT) g_q <= '0;
		if (state_q == S_OE) begin
			res_q.out_tag     <= tag_rd_q;
			res_q.group_index <= 6'(g_q);
			res_q.group_end   <= m_last;
			res_q.run_end     <= m_last && !g_more;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			max_d_q     <= DIST_RESET;
			found_q     <= 1'b0;
			ph_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= state_q == S_OE;
			if (cfg_valid && cfg_ready) max_d_q <= cfg_data;
			if (state_q == S_IDLE && accept && load_ok) cnt_q <= cnt_q + CW'(1);
			if (state_q == S_INIT) found_q <= 1'b0;
			if (state_q == S_CMP && upd) found_q <= 1'b1;
			if (state_q == S_DIV && div_cnt_q == DCW'(1)) ph_q <= !ph_q;
			if (state_q == S_SHR && state_d == S_INIT) cnt_q <= cnt_q - CW'(1);
			if (state_q == S_OE && state_d == S_IDLE) cnt_q <= '0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count beyond store depth");
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.run_end |-> result.group_end)
		else $error("run end without group end");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && point.last_point |=> busy) else $error("run did not start");
	a_keep_drop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MWR |-> keep_q < drop_q) else $error("merge slots out of order");
	a_merge_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MRD |-> found_q) else $error("merge without qualifying pair");
`endif

endmodule

`default_nettype wire

>>> tb/centroid_agglomerative_clusterer_tb.sv
`timescale 1ns / 1ps

module centroid_agglomerative_clusterer_tb;
	import cac_pkg::*;

	localparam int NPTS = 64;
	localparam int CYCLE_LIMIT = 3000000;

	class cluster_board;
		logic [15:0] px[NPTS];
		logic [15:0] py[NPTS];
		logic [63:0] ptag[NPTS];
		int          nlink[NPTS];
		logic [15:0] cx[NPTS];
		logic [15:0] cy[NPTS];
		logic [63:0] cmin[NPTS];
		int          csize[NPTS];
		int          chead[NPTS];
		int          ctail[NPTS];
		int          npoints;
		int          ngroups;
		logic [DIST_W-1:0] limit_sq;
		result_t     pending[$];
		int          errors;

		function new();
			limit_sq = DIST_RESET;
			npoints = 0;
			ngroups = 0;
			errors = 0;
		endfunction

		function bit group_before(int a, int b);
			if (cx[a] != cx[b])
				return cx[a] < cx[b];
			if (cy[a] != cy[b])
				return cy[a] < cy[b];
			return cmin[a] < cmin[b];
		endfunction

		function longint unsigned gap_sq(int a, int b);
			longint unsigned dx, dy;
			dx = cx[a] > cx[b] ? cx[a] - cx[b] : cx[b] - cx[a];
			dy = cy[a] > cy[b] ? cy[a] - cy[b] : cy[b] - cy[a];
			return dx * dx + dy * dy;
		endfunction

		function void merge_groups();
			bit found;
			int blo, bhi, lo, hi, keep, drop;
			longint unsigned bd, d, na, nb;
			while (ngroups > 1) begin
				found = 0;
				blo = 0;
				bhi = 0;
				bd = 0;
				for (int i = 0; i < ngroups; i++)
					for (int j = i + 1; j < ngroups; j++) begin
						d = gap_sq(i, j);
						if (d > limit_sq)
							continue;
						lo = group_before(i, j) ? i : j;
						hi = (lo == i) ? j : i;
						if (!found || d < bd || (d == bd && (group_before(lo, blo) ||
							(!group_before(blo, lo) && group_before(hi, bhi))))) begin
							found = 1;
							blo = lo;
							bhi = hi;
							bd = d;
						end
					end
				if (!found)
					break;
				keep = blo < bhi ? blo : bhi;
				drop = blo < bhi ? bhi : blo;
				na = csize[keep];
				nb = csize[drop];
				cx[keep] = 16'((cx[keep] * na + cx[drop] * nb) / (na + nb));
				cy[keep] = 16'((cy[keep] * na + cy[drop] * nb) / (na + nb));
				if (cmin[drop] < cmin[keep])
					cmin[keep] = cmin[drop];
				nlink[ctail[keep]] = chead[drop];
				ctail[keep] = ctail[drop];
				csize[keep] = int'(na + nb);
				for (int k = drop; k + 1 < ngroups; k++) begin
					cx[k] = cx[k+1];
					cy[k] = cy[k+1];
					cmin[k] = cmin[k+1];
					csize[k] = csize[k+1];
					chead[k] = chead[k+1];
					ctail[k] = ctail[k+1];
				end
				ngroups--;
			end
		endfunction

		function void note_point(point_t pt);
			result_t r;
			int p, n, total;
			if (npoints < NPTS) begin
				p = npoints;
				px[p] = pt.pos_x;
				py[p] = pt.pos_y;
				ptag[p] = pt.point_tag;
				nlink[p] = 0;
				cx[p] = pt.pos_x;
				cy[p] = pt.pos_y;
				cmin[p] = pt.point_tag;
				csize[p] = 1;
				chead[p] = p;
				ctail[p] = p;
				npoints++;
				ngroups = npoints;
			end
			if (!pt.last_point)
				return;
			merge_groups();
			total = 0;
			for (int g = 0; g < ngroups; g++) begin
				p = chead[g];
				for (int m = 0; m < csize[g] && p < NPTS; m++) begin
					r.out_tag = ptag[p];
					r.group_index = 6'(g);
					r.group_end = (m + 1 == csize[g]);
					r.run_end = 0;
					pending = {pending, r};
					total++;
					p = nlink[p];
				end
			end
			if (total > 0)
				pending[pending.size()-1].run_end = 1;
			npoints = 0;
			ngroups = 0;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result tag %h", got.out_tag);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_tag !== want.out_tag) begin
				$error("out_tag expected %h actual %h", want.out_tag, got.out_tag);
				errors++;
			end
			if (got.group_index !== want.group_index) begin
				$error("group_index expected %0d actual %0d", want.group_index,
					got.group_index);
				errors++;
			end
			if (got.group_end !== want.group_end) begin
				$error("group_end expected %0d actual %0d", want.group_end, got.group_end);
				errors++;
			end
			if (got.run_end !== want.run_end) begin
				$error("run_end expected %0d actual %0d", want.run_end, got.run_end);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	point_t point;
	logic result_valid;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [DIST_W-1:0] cfg_data;

	cluster_board board;
	int cycles;
	bit no_gaps;

	centroid_agglomerative_clusterer #(.MAX_POINTS(NPTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.point(point),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		board = new();
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid)
			board.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_point(input logic [15:0] x, input logic [15:0] y,
		input logic [63:0] tag, input bit last);
		point_t pt;
		pt.pos_x = x;
		pt.pos_y = y;
		pt.point_tag = tag;
		pt.last_point = last;
		while (!no_gaps && $urandom_range(99) < 37) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		point <= pt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_point(pt);
	endtask

	task automatic drain_results();
		start <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limit(input logic [DIST_W-1:0] v);
		drain_results();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.limit_sq = v;
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] near(input logic [15:0] c, input int spread);
		int v;
		v = int'(c) + $urandom_range(2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	task automatic random_set(input int count);
		logic [15:0] bx[4];
		logic [15:0] by[4];
		int c;
		for (int k = 0; k < 4; k++) begin
			bx[k] = 16'($urandom);
			by[k] = 16'($urandom);
		end
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(3);
			if ($urandom_range(9) < 2)
				send_point(16'($urandom), 16'($urandom), {$urandom, $urandom},
					i == count - 1);
			else
				send_point(near(bx[c], 1200), near(by[c], 1200), {$urandom, $urandom},
					i == count - 1);
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		point = '0;
		cfg_valid = 0;
		cfg_data = '0;
		no_gaps = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single point, then extremes with reset limit
		send_point(16'h0000, 16'h0000, 64'h0, 1);
		send_point(16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_point(16'h0000, 16'h0000, 64'h0, 0);
		send_point(16'h0100, 16'h0100, 64'h5, 0);
		send_point(16'h0100, 16'h0100, 64'h3, 1);
		// equal distance ties
		send_point(16'h1000, 16'h1000, 64'h10, 0);
		send_point(16'h1200, 16'h1000, 64'h11, 0);
		send_point(16'h1400, 16'h1000, 64'h12, 0);
		send_point(16'h1000, 16'h1200, 64'h13, 1);
		set_limit('0);
		send_point(16'h2000, 16'h2000, 64'h7, 0);
		send_point(16'h2000, 16'h2000, 64'h6, 0);
		send_point(16'h2001, 16'h2000, 64'h8, 1);
		set_limit({DIST_W{1'b1}});
		send_point(16'h0000, 16'hFFFF, 64'hA, 0);
		send_point(16'hFFFF, 16'h0000, 64'hB, 0);
		send_point(16'h8000, 16'h8000, 64'hC, 1);
		// overflow: more than the store holds
		set_limit(DIST_RESET);
		no_gaps = 1;
		random_set(NPTS + 3);
		no_gaps = 0;

		set_limit(33'd4000000);
		random_set(6);
		set_limit(33'd40000000);
		random_set(4);
		set_limit({1'b1, 32'($urandom)});
		random_set(3);
		no_gaps = 1;
		set_limit(DIST_RESET);
		random_set(5);
		no_gaps = 0;
		set_limit(33'($urandom_range(9000000)));
		random_set(4);
		set_limit(33'd1);
		random_set(2);
		set_limit(DIST_RESET);
		random_set(3);
		for (int i = 0; i < 3; i++)
			random_set(1 + $urandom_range(2));

		drain_results();
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
